>>> hdl/svr_pkg.sv
// Shared types, constants and the byte-wide CRC-32 step for the stored-record validator.
// No dependencies; every other file uses this package.
package svr_pkg;

    localparam int unsigned FW_W  = 16;
    localparam int unsigned IDX_W = 2;
    localparam int unsigned POS_W = 5;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] CFG_FW_MAJOR = 2'd0;
    localparam logic [IDX_W-1:0] CFG_FW_MINOR = 2'd1;

    localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ONES     = 32'hFFFF_FFFF;
    localparam logic [31:0] META_MAGIC   = 32'h3153_505A;
    localparam logic [31:0] ACTIVE_MAGIC = 32'h3141_505A;

    localparam logic [7:0] STATE_PREPARED  = 8'd1;
    localparam logic [7:0] STATE_COMMITTED = 8'd2;
    localparam logic [15:0] FORMAT_VERSION = 16'd1;

    // Covered prefix lengths and final byte positions
    localparam logic [POS_W-1:0] META_COVER  = 5'd28;
    localparam logic [POS_W-1:0] ACTIVE_COVER = 5'd12;
    localparam logic [POS_W-1:0] META_LAST   = 5'd31;
    localparam logic [POS_W-1:0] ACTIVE_LAST = 5'd15;

    // Word index within a record (byte position / 4)
    localparam logic [2:0] W_MAGIC = 3'd0;
    localparam logic [2:0] W_HDR   = 3'd1;
    localparam logic [2:0] W_GEN   = 3'd2;
    localparam logic [2:0] W_LEN   = 3'd3;
    localparam logic [2:0] W_ICRC  = 3'd4;
    localparam logic [2:0] W_FW    = 3'd5;
    localparam logic [2:0] W_RSV   = 3'd6;
    localparam logic [2:0] W_CRC   = 3'd7;

    typedef struct packed {
        logic       kind;
        logic [7:0] record_byte;
        logic       expected_slot;
        logic       accept_prepared;
    } t_beat;

    typedef struct packed {
        logic        valid_res;
        logic [31:0] generation;
        logic [31:0] program_length;
        logic [31:0] image_crc;
        logic        named_slot;
    } t_result;

    // Reflected CRC-32, one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> hdl/svr_if.sv
// Channel interfaces: record byte input, verdict output, configuration writes.
// Depends on svr_pkg for widths.
interface svr_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] record_byte;
    logic       expected_slot;
    logic       accept_prepared;
    modport source (output valid, kind, record_byte, expected_slot, accept_prepared,
                    input ready);
    modport sink   (input valid, kind, record_byte, expected_slot, accept_prepared,
                    output ready);
endinterface

interface svr_out_if;
    logic        valid;
    logic        ready;
    logic        valid_res;
    logic [31:0] generation;
    logic [31:0] program_length;
    logic [31:0] image_crc;
    logic        named_slot;
    modport source (output valid, valid_res, generation, program_length, image_crc,
                    named_slot, input ready);
    modport sink   (input valid, valid_res, generation, program_length, image_crc,
                    named_slot, output ready);
endinterface

interface svr_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [svr_pkg::IDX_W-1:0]   index;
    logic [svr_pkg::FW_W-1:0]    data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/svr_in_stage.sv
// Input register: holds one record byte beat until the core consumes it.
// Depends on svr_pkg and svr_in_if.
module svr_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    svr_in_if.sink          i_in,
    input  logic            i_take,
    output logic            o_valid,
    output svr_pkg::t_beat  o_beat
);
    import svr_pkg::*;

    logic  r_valid;
    t_beat r_beat;
    logic  w_acc;

    assign i_in.ready = !r_valid || i_take;
    assign w_acc      = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_acc) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_beat.kind            <= i_in.kind;
            r_beat.record_byte     <= i_in.record_byte;
            r_beat.expected_slot   <= i_in.expected_slot;
            r_beat.accept_prepared <= i_in.accept_prepared;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;
endmodule

>>> hdl/svr_core.sv
// Record state: byte position, running CRC, word assembly, field checks and captures.
// Depends on svr_pkg.
module svr_core (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_beat_valid,
    input  svr_pkg::t_beat          i_beat,
    input  logic [svr_pkg::FW_W-1:0] i_fw_major,
    input  logic [svr_pkg::FW_W-1:0] i_fw_minor,
    input  logic                    i_out_free,
    output logic                    o_take,
    output logic                    o_res_valid,
    output svr_pkg::t_result        o_res
);
    import svr_pkg::*;

    logic [POS_W-1:0] r_pos;
    logic [31:0]      r_crc;
    logic             r_kind, r_slot_wanted, r_prep_ok, r_checks;
    logic [31:0]      r_shift, r_gen, r_len, r_icrc;
    logic             r_cslot;

    logic             w_first, w_kind, w_slot, w_prep, w_last, w_ok;
    logic [POS_W-1:0] w_cover;
    logic [31:0]      n_crc, n_shift, w_crc_fin;
    logic [7:0]       w_state;
    logic             w_cap_gen, w_cap_len, w_cap_icrc, w_cap_slot, w_checks;

    assign w_first   = (r_pos == '0);
    assign w_kind    = w_first ? i_beat.kind            : r_kind;
    assign w_slot    = w_first ? i_beat.expected_slot   : r_slot_wanted;
    assign w_prep    = w_first ? i_beat.accept_prepared : r_prep_ok;
    assign w_cover   = w_kind ? ACTIVE_COVER : META_COVER;
    assign w_last    = (r_pos == (w_kind ? ACTIVE_LAST : META_LAST));
    assign n_crc     = (r_pos < w_cover) ? crc_byte(r_crc, i_beat.record_byte) : r_crc;
    assign n_shift   = {i_beat.record_byte, r_shift[31:8]};
    assign w_crc_fin = n_crc ^ CRC_ONES;
    assign w_state   = n_shift[31:24];

    // Word check on the fourth byte of each little-endian word
    always_comb begin
        w_ok       = 1'b1;
        w_cap_gen  = 1'b0;
        w_cap_len  = 1'b0;
        w_cap_icrc = 1'b0;
        w_cap_slot = 1'b0;
        if (r_pos[1:0] == 2'd3) begin
            if (w_kind) begin
                case (r_pos[4:2])
                    W_MAGIC: w_ok = (n_shift == ACTIVE_MAGIC);
                    W_HDR: begin
                        w_cap_slot = 1'b1;
                        w_ok = (n_shift[15:0] == FORMAT_VERSION) &&
                               (n_shift[23:17] == 7'd0) && (n_shift[31:24] == 8'd0);
                    end
                    W_GEN: begin
                        w_cap_gen = 1'b1;
                        w_ok = (n_shift != 32'd0);
                    end
                    default: w_ok = (n_shift == w_crc_fin);
                endcase
            end else begin
                case (r_pos[4:2])
                    W_MAGIC: w_ok = (n_shift == META_MAGIC);
                    W_HDR: begin
                        w_ok = (n_shift[15:0] == FORMAT_VERSION) &&
                               (n_shift[23:16] == {7'd0, w_slot}) &&
                               ((w_state == STATE_COMMITTED) ||
                                (w_prep && (w_state == STATE_PREPARED)));
                    end
                    W_GEN: begin
                        w_cap_gen = 1'b1;
                        w_ok = (n_shift != 32'd0);
                    end
                    W_LEN: begin
                        w_cap_len = 1'b1;
                        w_ok = (n_shift != 32'd0);
                    end
                    W_ICRC: w_cap_icrc = 1'b1;
                    W_FW: w_ok = (n_shift[15:0] == i_fw_major) &&
                                 (n_shift[31:16] == i_fw_minor);
                    W_RSV: w_ok = (n_shift == 32'd0);
                    default: w_ok = (n_shift == w_crc_fin);
                endcase
            end
        end
    end

    assign w_checks    = r_checks && w_ok;
    assign o_take      = i_beat_valid && (!w_last || i_out_free);
    assign o_res_valid = o_take && w_last;

    // Captures happen before the final byte, so the registered copies are current here
    always_comb begin
        o_res.valid_res      = w_checks;
        o_res.generation     = w_checks ? r_gen : 32'd0;
        o_res.program_length = (w_checks && !w_kind) ? r_len : 32'd0;
        o_res.image_crc      = (w_checks && !w_kind) ? r_icrc : 32'd0;
        o_res.named_slot     = w_kind ? r_cslot : w_slot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos         <= '0;
            r_crc         <= CRC_ONES;
            r_checks      <= 1'b1;
            r_kind        <= 1'b0;
            r_slot_wanted <= 1'b0;
            r_prep_ok     <= 1'b0;
        end else if (o_take) begin
            r_kind        <= w_kind;
            r_slot_wanted <= w_slot;
            r_prep_ok     <= w_prep;
            if (w_last) begin
                r_pos    <= '0;
                r_crc    <= CRC_ONES;
                r_checks <= 1'b1;
            end else begin
                r_pos    <= r_pos + POS_W'(1);
                r_crc    <= n_crc;
                r_checks <= w_checks;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_shift <= n_shift;
            if (w_cap_gen) begin
                r_gen <= n_shift;
            end
            if (w_cap_len) begin
                r_len <= n_shift;
            end
            if (w_cap_icrc) begin
                r_icrc <= n_shift;
            end
            if (w_cap_slot) begin
                r_cslot <= n_shift[16];
            end
        end
    end
endmodule

>>> hdl/svr_out_stage.sv
// Result register: holds one verdict until the sink takes it.
// Depends on svr_pkg and svr_out_if.
module svr_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  svr_pkg::t_result  i_res,
    output logic              o_free,
    svr_out_if.source         o_out
);
    import svr_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_free = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.valid_res      = r_res.valid_res;
    assign o_out.generation     = r_res.generation;
    assign o_out.program_length = r_res.program_length;
    assign o_out.image_crc      = r_res.image_crc;
    assign o_out.named_slot     = r_res.named_slot;
endmodule

>>> hdl/store_record_validator_top.sv
// Top level of the stored-record validator: input register, record core, result register,
// firmware version registers. Depends on svr_pkg, svr_if, svr_in_stage, svr_core, svr_out_stage.
//
//  channel  dir  handshake        payload
//  i_in     in   valid / ready    kind, record_byte, expected_slot, accept_prepared
//  o_out    out  valid / ready    valid_res, generation, program_length, image_crc, named_slot
//  i_cfg    in   valid / ready    index (0 fw major, 1 fw minor), data[15:0]
//
// One byte beat per cycle unless stalled; a beat is held in the input register, and the
// CRC step plus word check run in the cycle it leaves it; the verdict is loaded into the
// result register as the record's last byte beat leaves. Reset (i_rst_n low at a clock edge) clears both stages and
// starts a new record; firmware registers return to zero. The input stalls only when the last
// byte of a record meets a result register that is still full and not being taken.
// Config writes are always ready and take effect on the next cycle.
module store_record_validator_top (
    input  logic    i_clk,
    input  logic    i_rst_n,
    svr_in_if.sink  i_in,
    svr_out_if.source o_out,
    svr_cfg_if.sink i_cfg
);
    import svr_pkg::*;

    logic            w_beat_valid;
    t_beat           w_beat;
    logic            w_take;
    logic            w_out_free;
    logic            w_res_valid;
    t_result         w_res;
    logic [FW_W-1:0] r_fw_major, r_fw_minor;

    // Firmware version registers; writes to unused indexes fall through
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw_major <= '0;
            r_fw_minor <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_FW_MAJOR: r_fw_major <= i_cfg.data;
                CFG_FW_MINOR: r_fw_minor <= i_cfg.data;
                default: ;
            endcase
        end
    end

    svr_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (w_take),
        .o_valid (w_beat_valid),
        .o_beat  (w_beat)
    );

    svr_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_beat_valid (w_beat_valid),
        .i_beat       (w_beat),
        .i_fw_major   (r_fw_major),
        .i_fw_minor   (r_fw_minor),
        .i_out_free   (w_out_free),
        .o_take       (w_take),
        .o_res_valid  (w_res_valid),
        .o_res        (w_res)
    );

    svr_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_res_valid),
        .i_res   (w_res),
        .o_free  (w_out_free),
        .o_out   (o_out)
    );

    // A verdict never overwrites one that is still waiting
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |-> w_out_free)
        else $error("verdict loaded into a full result register");

    // The core consumes only a held beat
    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> w_beat_valid)
        else $error("core consumed an empty input register");

    // A failed record reports no captured words
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_valid && !w_res.valid_res) |->
        (w_res.generation == 32'd0 && w_res.program_length == 32'd0 &&
         w_res.image_crc == 32'd0))
        else $error("failed verdict carries nonzero fields");

    // A loaded verdict is shown on the next cycle
    a_load_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |=> o_out.valid)
        else $error("loaded verdict not presented");
endmodule
